// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define GLS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/gls_pkg.sv =====
`default_nettype none

package gls_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned VTX_BITS  = 6;
  localparam int unsigned DIST_BITS = 21;
  localparam int unsigned VCNT_BITS = 5;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [DIST_BITS-1:0] DIST_SAT = '1;
  localparam logic [VCNT_BITS-1:0] VCNT_RST = 5'd16;

  localparam logic [1:0] CMD_SET     = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // register index as decoded from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_IS_DIRECTED  = 1'b1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [VTX_BITS-1:0] src_vertex;
    logic [VTX_BITS-1:0] dst_vertex;
    logic signed [15:0]  edge_weight;
  } gls_in_t;

  typedef struct packed {
    logic                 index_error;
    logic                 found;
    logic [DIST_BITS-1:0] longest_distance;
    logic [VTX_BITS-1:0]  from_vertex;
    logic [VTX_BITS-1:0]  to_vertex;
  } gls_out_t;

endpackage

`default_nettype wire

// ===== src/graph_longest_shortest_path.sv =====
// Graph diameter engine. Words are commands on an adjacency matrix held in RAM:
// set edge and remove edge write one entry (and the mirrored entry as well when
// undirected); a remove with an out-of-range vertex returns an error word. Compute
// rebuilds the distance matrix in RAM with Floyd-Warshall and scans it for the
// longest shortest path over the n active vertices, with read-modify-write passes
// over the distance RAM. After reset a clearing pass zeroes all
// 2**(2*clog2(MAX_VERTICES)) entries (256 by default) of the adjacency RAM,
// during which no word is taken.
`default_nettype none

`include "assert_macros.svh"

module graph_longest_shortest_path
  import gls_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire gls_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output gls_out_t                out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned VB    = $clog2(MAX_VERTICES);
  localparam int unsigned AW    = 2 * VB;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned NW    = VB + 1;
  localparam int unsigned DB    = WEIGHT_BITS + VB;
  localparam int unsigned DW    = DB + 1;
  localparam int unsigned SW    = (DB > DIST_BITS) ? DB : DIST_BITS;
  localparam int unsigned CW    = (NW > VCNT_BITS) ? NW : VCNT_BITS;
  localparam int unsigned XW    = (NW > VTX_BITS) ? NW : VTX_BITS;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_MIRROR   = 4'd2;
  localparam logic [3:0] ST_INIT     = 4'd3;
  localparam logic [3:0] ST_INIT_END = 4'd4;
  localparam logic [3:0] ST_IK       = 4'd5;
  localparam logic [3:0] ST_IKW      = 4'd6;
  localparam logic [3:0] ST_J        = 4'd7;
  localparam logic [3:0] ST_SCAN     = 4'd8;
  localparam logic [3:0] ST_SCAN_END = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;
  localparam logic [3:0] ST_EMIT     = 4'd11;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_FW   = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  logic [3:0] state_q, state_d;
  logic [VB-1:0] ck_q, ck_d, ci_q, ci_d, cj_q, cj_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] mir_addr_q, mir_addr_d;
  logic [WEIGHT_BITS-1:0] mir_w_q, mir_w_d;
  logic pv_q, pv_d;
  logic [1:0] pmode_q, pmode_d;
  logic [VB-1:0] pi_q, pi_d, pj_q, pj_d;
  logic [DB-1:0] dik_q, dik_d;
  logic [DB-1:0] best_q, best_d;
  logic [VB-1:0] bi_q, bi_d, bj_q, bj_d;
  gls_out_t res_q, res_d;
  logic out_valid_q;
  gls_out_t out_q;
  logic [VCNT_BITS-1:0] vcount_q;
  logic isdir_q;

  logic adj_we;
  logic [AW-1:0] adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
  logic dist_we, a_rd;
  logic [AW-1:0] dist_waddr, dist_raddr_a, dist_raddr_b;
  logic [DW-1:0] dist_wdata, dist_a_rdata, dist_b_rdata;

  gls_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  // two copies of the distance matrix give two read ports
  gls_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist_a_ram (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr_a), .rdata_o(dist_a_rdata)
  );

  gls_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist_b_ram (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr_b), .rdata_o(dist_b_rdata)
  );

  // active vertex count, saturated to the matrix size
  logic [CW-1:0] vc_ext;
  logic [NW-1:0] n_act, nm1;
  assign vc_ext = CW'(vcount_q);
  assign n_act  = (vc_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_ext);
  assign nm1    = n_act - NW'(1);

  logic ci_last, cj_last, ck_last;
  assign ci_last = ({1'b0, ci_q} == nm1);
  assign cj_last = ({1'b0, cj_q} == nm1);
  assign ck_last = ({1'b0, ck_q} == nm1);

  logic in_fire, idx_ok;
  logic signed [31:0] w_ext;
  logic [WEIGHT_BITS-1:0] w_wrap;
  logic [VB-1:0] s_idx, d_idx;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign idx_ok     = (XW'(in_data_i.src_vertex) < XW'(n_act)) &&
                      (XW'(in_data_i.dst_vertex) < XW'(n_act));
  assign w_ext      = 32'(in_data_i.edge_weight);
  assign w_wrap     = w_ext[WEIGHT_BITS-1:0];
  assign s_idx      = in_data_i.src_vertex[VB-1:0];
  assign d_idx      = in_data_i.dst_vertex[VB-1:0];

  // pipeline stage datapath
  logic adj_pos, upd;
  logic [DB:0] via;
  assign adj_pos = !adj_rdata[WEIGHT_BITS-1] && (adj_rdata != '0);
  assign via     = {1'b0, dik_q} + {1'b0, dist_a_rdata[DB-1:0]};
  assign upd     = dist_a_rdata[DB] &&
                   (!dist_b_rdata[DB] || (via < {1'b0, dist_b_rdata[DB-1:0]}));

  logic [SW-1:0] best_w;
  assign best_w = SW'(best_q);

  always_comb begin
    state_d    = state_q;
    ck_d       = ck_q;
    ci_d       = ci_q;
    cj_d       = cj_q;
    clr_d      = clr_q;
    mir_addr_d = mir_addr_q;
    mir_w_d    = mir_w_q;
    dik_d      = dik_q;
    best_d     = best_q;
    bi_d       = bi_q;
    bj_d       = bj_q;
    res_d      = res_q;
    pv_d       = 1'b0;
    pmode_d    = pmode_q;
    pi_d       = ci_q;
    pj_d       = cj_q;
    adj_we     = 1'b0;
    adj_waddr  = clr_q;
    adj_wdata  = '0;
    adj_raddr  = {ci_q, cj_q};
    dist_raddr_a = {ci_q, cj_q};
    dist_raddr_b = {ci_q, cj_q};
    a_rd       = 1'b0;
    dist_we    = 1'b0;
    dist_waddr = {pi_q, pj_q};
    dist_wdata = '0;

    unique case (state_q)
      ST_CLEAR: begin
        adj_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.cmd) inside
            CMD_SET, CMD_REMOVE: begin
              if (idx_ok) begin
                adj_we     = 1'b1;
                adj_waddr  = {s_idx, d_idx};
                adj_wdata  = (in_data_i.cmd == CMD_SET) ? w_wrap : '0;
                mir_addr_d = {d_idx, s_idx};
                mir_w_d    = adj_wdata;
                if (!isdir_q) begin
                  state_d = ST_MIRROR;
                end
              end else if (in_data_i.cmd == CMD_REMOVE) begin
                res_d             = '0;
                res_d.index_error = 1'b1;
                state_d           = ST_EMIT;
              end
            end
            CMD_COMPUTE: begin
              best_d = '0;
              bi_d   = '0;
              bj_d   = '0;
              ci_d   = '0;
              cj_d   = '0;
              ck_d   = '0;
              if (n_act == '0) begin
                res_d   = '0;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MIRROR: begin
        adj_we    = 1'b1;
        adj_waddr = mir_addr_q;
        adj_wdata = mir_w_q;
        state_d   = ST_IDLE;
      end
      ST_INIT: begin
        pv_d    = 1'b1;
        pmode_d = MODE_INIT;
        cj_d    = cj_q + VB'(1);
        if (cj_last) begin
          cj_d = '0;
          ci_d = ci_q + VB'(1);
          if (ci_last) begin
            ci_d    = '0;
            state_d = ST_INIT_END;
          end
        end
      end
      ST_INIT_END: begin
        state_d = ST_IK;
      end
      ST_IK: begin
        a_rd         = 1'b1;
        dist_raddr_a = {ci_q, ck_q};
        state_d      = ST_IKW;
      end
      ST_IKW, ST_J: begin
        if (state_q == ST_IKW) begin
          dik_d = dist_a_rdata[DB-1:0];
          cj_d  = '0;
        end else begin
          a_rd         = 1'b1;
          dist_raddr_a = {ck_q, cj_q};
          pv_d         = 1'b1;
          pmode_d      = MODE_FW;
          cj_d         = cj_q + VB'(1);
        end
        if (state_q == ST_IKW && dist_a_rdata[DB]) begin
          state_d = ST_J;
        end else if (state_q == ST_IKW || cj_last) begin
          // next row, or next pivot after the last row
          cj_d    = '0;
          state_d = ST_IK;
          ci_d    = ci_q + VB'(1);
          if (ci_last) begin
            ci_d = '0;
            ck_d = ck_q + VB'(1);
            if (ck_last) begin
              ck_d    = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        a_rd    = 1'b1;
        pv_d    = 1'b1;
        pmode_d = MODE_SCAN;
        cj_d    = cj_q + VB'(1);
        if (cj_last) begin
          cj_d = '0;
          ci_d = ci_q + VB'(1);
          if (ci_last) begin
            ci_d    = '0;
            state_d = ST_SCAN_END;
          end
        end
      end
      ST_SCAN_END: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        res_d.index_error      = 1'b0;
        res_d.found            = (best_q != '0);
        res_d.longest_distance = (best_w > SW'(DIST_SAT)) ? DIST_SAT : DIST_BITS'(best_w);
        res_d.from_vertex      = VTX_BITS'(bi_q);
        res_d.to_vertex        = VTX_BITS'(bj_q);
        state_d                = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (pv_q) begin
      case (pmode_q)
        MODE_INIT: begin
          dist_we = 1'b1;
          if (pi_q == pj_q) begin
            dist_wdata = {1'b1, DB'(0)};
          end else if (adj_pos) begin
            dist_wdata = {1'b1, DB'(adj_rdata)};
          end
        end
        MODE_FW: begin
          dist_we    = upd;
          dist_wdata = {1'b1, via[DB-1:0]};
        end
        MODE_SCAN: begin
          // strict compare keeps the first pair in row-major order
          if (pi_q < pj_q && dist_a_rdata[DB] && dist_a_rdata[DB-1:0] > best_q) begin
            best_d = dist_a_rdata[DB-1:0];
            bi_d   = pi_q;
            bj_d   = pj_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      vcount_q    <= VCNT_RST;
      isdir_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pv_q    <= pv_d;
      if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          REG_VERTEX_COUNT: vcount_q <= pwdata[VCNT_BITS-1:0];
          REG_IS_DIRECTED:  isdir_q  <= pwdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ck_q       <= ck_d;
    ci_q       <= ci_d;
    cj_q       <= cj_d;
    mir_addr_q <= mir_addr_d;
    mir_w_q    <= mir_w_d;
    pmode_q    <= pmode_d;
    pi_q       <= pi_d;
    pj_q       <= pj_d;
    dik_q      <= dik_d;
    best_q     <= best_d;
    bi_q       <= bi_d;
    bj_q       <= bj_d;
    res_q      <= res_d;
    if (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_IS_DIRECTED) ? 32'(isdir_q) : 32'(vcount_q);

  `GLS_ASSERT(a_idle_no_dist_wr, state_q == ST_IDLE |-> !dist_we, "distance write while idle")
  `GLS_ASSERT(a_pivot_row_fixed, pv_q && pmode_q == MODE_FW && pi_q == ck_q |-> !dist_we, "pivot row updated")
  `GLS_ASSERT_NEVER(a_rw_collision, dist_we && a_rd && dist_waddr == dist_raddr_a, "read of entry being written")
  `GLS_ASSERT(a_emit_exit, state_q == ST_EMIT |=> state_q == ST_EMIT || state_q == ST_IDLE, "bad exit from emit")

endmodule

`default_nettype wire

// ===== src/gls_ram.sv =====
`default_nettype none

module gls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
